[design/evr_pkg.sv]
// Package for the eased value ramp: fixed-point widths, register indexes,
// microcode opcodes and the microcode program. No dependencies.
`default_nettype none

package evr_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int TIME_BITS  = 32;
   localparam int VALUE_W    = 32;
   localparam int LAT_W      = 32;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Compare and divide widths cover both the tick counter and the latency.
   localparam int CMP_W      = (TIME_BITS > LAT_W) ? TIME_BITS : LAT_W;
   localparam int DIV_W      = CMP_W + 1;
   localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);
   localparam int PROD_W     = VALUE_W + FRAC_BITS + 2;
   localparam int PC_W       = 4;

   localparam logic [DIV_CNT_W-1:0] DIV_CNT_INIT = DIV_CNT_W'(FRAC_BITS);
   localparam logic [DIV_CNT_W-1:0] DIV_CNT_ONE  = DIV_CNT_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LATENCY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT    = 2'd2;

   localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SQUARED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CUBED   = 2'd2;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_SET  = 1'b1;

   typedef enum logic [3:0] {
      OP_ACCEPT,
      OP_PREP,
      OP_DIV,
      OP_SQUARE,
      OP_CUBE,
      OP_SCALE,
      OP_SUM,
      OP_GOAL,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      C_REQ,
      C_SETTLED,
      C_DIV_LAST,
      C_ALWAYS,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] next_true;
      logic [PC_W-1:0] next_false;
   } ctrl_word_type;

   localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
   localparam logic [PC_W-1:0] STEP_PREP   = 4'd1;
   localparam logic [PC_W-1:0] STEP_DIV    = 4'd2;
   localparam logic [PC_W-1:0] STEP_SQUARE = 4'd3;
   localparam logic [PC_W-1:0] STEP_CUBE   = 4'd4;
   localparam logic [PC_W-1:0] STEP_SCALE  = 4'd5;
   localparam logic [PC_W-1:0] STEP_SUM    = 4'd6;
   localparam logic [PC_W-1:0] STEP_GOAL   = 4'd7;
   localparam logic [PC_W-1:0] STEP_EMIT   = 4'd8;

   // The program: one control word per step, with a branch on a condition.
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      case (pc)
         STEP_WAIT:   w = '{OP_ACCEPT, C_REQ,      STEP_PREP,   STEP_WAIT};
         STEP_PREP:   w = '{OP_PREP,   C_SETTLED,  STEP_GOAL,   STEP_DIV};
         STEP_DIV:    w = '{OP_DIV,    C_DIV_LAST, STEP_SQUARE, STEP_DIV};
         STEP_SQUARE: w = '{OP_SQUARE, C_ALWAYS,   STEP_CUBE,   STEP_CUBE};
         STEP_CUBE:   w = '{OP_CUBE,   C_ALWAYS,   STEP_SCALE,  STEP_SCALE};
         STEP_SCALE:  w = '{OP_SCALE,  C_ALWAYS,   STEP_SUM,    STEP_SUM};
         STEP_SUM:    w = '{OP_SUM,    C_ALWAYS,   STEP_EMIT,   STEP_EMIT};
         STEP_GOAL:   w = '{OP_GOAL,   C_ALWAYS,   STEP_EMIT,   STEP_EMIT};
         STEP_EMIT:   w = '{OP_EMIT,   C_OUT_FREE, STEP_WAIT,   STEP_EMIT};
         default:     w = '{OP_ACCEPT, C_REQ,      STEP_PREP,   STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[design/evr_if.sv]
// Handshake channels of the eased value ramp: request and response.
// Depends on evr_pkg for the payload widths.
`default_nettype none

interface evr_req_if;
   logic                              valid;
   logic                              ready;
   logic                              func;
   logic signed [evr_pkg::VALUE_W-1:0] target;

   modport source (output valid, output func, output target, input ready);
   modport sink   (input valid, input func, input target, output ready);
endinterface

interface evr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [evr_pkg::VALUE_W-1:0] value;
   logic                              settled;

   modport source (output valid, output value, output settled, input ready);
   modport sink   (input valid, input value, input settled, output ready);
endinterface

`default_nettype wire

[design/eased_value_ramp.sv]
// Eased value ramp: a microcoded sequencer over a fixed-point datapath.
// Depends on evr_pkg (constants, opcodes, program) and evr_if (channels).
//
//   channel  direction  handshake     payload
//   req      in         valid/ready   func, target
//   rsp      out        valid/ready   value, settled
//   csr      in         csr_we        csr_index, csr_wdata (write only)
//
// An item that leaves the ramp settled passes through the accept, prep, goal
// and emit steps to the response register. An item that is still ramping
// passes through accept, prep, divide, square, cube, scale, sum and emit, and
// its restoring divider yields one bit of the fraction per cycle. Reset is
// synchronous and clears the program counter, configuration registers, ramp
// state and response valid flag to zero. The next transaction is accepted as
// soon as the result sits in the response register; a stalled response only
// holds the sequencer when the following result is ready to be written.
`default_nettype none

module eased_value_ramp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   evr_req_if.sink                                  req,
   evr_rsp_if.source                                rsp,
   input  wire logic                                csr_we,
   input  wire logic [evr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [evr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Sequencer state.
   logic [evr_pkg::PC_W-1:0]             pc_ff, pc_in;
   evr_pkg::ctrl_word_type               ctrl;
   logic                                 cond_hit;

   // Configuration registers.
   logic [evr_pkg::MODE_W-1:0]           mode_ff, mode_in;
   logic [evr_pkg::LAT_W-1:0]            latency_ff, latency_in;

   // Ramp state.
   logic signed [evr_pkg::VALUE_W-1:0]   start_value_ff, start_value_in;
   logic signed [evr_pkg::VALUE_W-1:0]   goal_value_ff, goal_value_in;
   logic signed [evr_pkg::VALUE_W-1:0]   current_value_ff, current_value_in;
   logic [evr_pkg::TIME_BITS-1:0]        elapsed_ff, elapsed_in;

   // Datapath working registers.
   logic [evr_pkg::DIV_W-1:0]            rem_ff, rem_in;
   logic [evr_pkg::FRAC_BITS-1:0]        quot_ff, quot_in;
   logic [evr_pkg::DIV_CNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic [evr_pkg::FRAC_BITS-1:0]        sq_ff, sq_in;
   logic [evr_pkg::FRAC_BITS-1:0]        cube_ff, cube_in;
   logic signed [evr_pkg::VALUE_W:0]     diff_ff, diff_in;
   logic signed [evr_pkg::PROD_W-1:0]    prod_ff, prod_in;

   // Response register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [evr_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                                 rsp_settled_ff, rsp_settled_in;

   // Combinational helpers.
   logic [evr_pkg::DIV_W-1:0]            elapsed_ext;
   logic [evr_pkg::DIV_W-1:0]            latency_ext;
   logic [evr_pkg::DIV_W-1:0]            rem_shift;
   logic                                 settled;
   logic                                 out_free;
   logic                                 req_take;
   logic [2*evr_pkg::FRAC_BITS-1:0]      sq_full;
   logic [2*evr_pkg::FRAC_BITS-1:0]      cube_full;
   logic [evr_pkg::FRAC_BITS-1:0]        curve;
   logic signed [evr_pkg::FRAC_BITS:0]   curve_s;
   logic signed [evr_pkg::PROD_W-1:0]    step_full;

   assign ctrl = evr_pkg::ucode(pc_ff);

   assign elapsed_ext = {{(evr_pkg::DIV_W - evr_pkg::TIME_BITS){1'b0}}, elapsed_ff};
   assign latency_ext = {{(evr_pkg::DIV_W - evr_pkg::LAT_W){1'b0}}, latency_ff};
   assign settled     = (elapsed_ext >= latency_ext);
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign req_take    = (ctrl.op == evr_pkg::OP_ACCEPT) && req.valid;
   assign rem_shift   = {rem_ff[evr_pkg::DIV_W-2:0], 1'b0};

   assign sq_full   = quot_ff * quot_ff;
   assign cube_full = sq_ff * quot_ff;

   // The curve is chosen by mode; the undefined fourth code holds at start.
   always_comb begin
      case (mode_ff)
         evr_pkg::MODE_LINEAR:  curve = quot_ff;
         evr_pkg::MODE_SQUARED: curve = sq_ff;
         evr_pkg::MODE_CUBED:   curve = cube_ff;
         default:               curve = '0;
      endcase
   end

   assign curve_s   = signed'({1'b0, curve});
   // Arithmetic shift gives the floor of the scaled step.
   assign step_full = prod_ff >>> evr_pkg::FRAC_BITS;

   always_comb begin
      case (ctrl.cond)
         evr_pkg::C_REQ:      cond_hit = req.valid;
         evr_pkg::C_SETTLED:  cond_hit = settled;
         evr_pkg::C_DIV_LAST: cond_hit = (div_cnt_ff == evr_pkg::DIV_CNT_ONE);
         evr_pkg::C_ALWAYS:   cond_hit = 1'b1;
         evr_pkg::C_OUT_FREE: cond_hit = out_free;
         default:             cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      pc_in            = cond_hit ? ctrl.next_true : ctrl.next_false;
      mode_in          = mode_ff;
      latency_in       = latency_ff;
      start_value_in   = start_value_ff;
      goal_value_in    = goal_value_ff;
      current_value_in = current_value_ff;
      elapsed_in       = elapsed_ff;
      rem_in           = rem_ff;
      quot_in          = quot_ff;
      div_cnt_in       = div_cnt_ff;
      sq_in            = sq_ff;
      cube_in          = cube_ff;
      diff_in          = diff_ff;
      prod_in          = prod_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_settled_in   = rsp_settled_ff;

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (ctrl.op)
         evr_pkg::OP_ACCEPT: begin
            if (req_take) begin
               if (req.func == evr_pkg::FUNC_SET) begin
                  // A new target restarts the ramp from where the value is now.
                  start_value_in = current_value_ff;
                  goal_value_in  = req.target;
                  elapsed_in     = '0;
               end else if (!settled && (elapsed_ff != '1)) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
         end
         evr_pkg::OP_PREP: begin
            // The divide follows only while elapsed is below latency, so the fraction stays below unity.
            rem_in     = elapsed_ext;
            quot_in    = '0;
            div_cnt_in = evr_pkg::DIV_CNT_INIT;
            diff_in    = {goal_value_ff[evr_pkg::VALUE_W-1], goal_value_ff}
                       - {start_value_ff[evr_pkg::VALUE_W-1], start_value_ff};
         end
         evr_pkg::OP_DIV: begin
            div_cnt_in = div_cnt_ff - 1'b1;
            if (rem_shift >= latency_ext) begin
               rem_in  = rem_shift - latency_ext;
               quot_in = {quot_ff[evr_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               quot_in = {quot_ff[evr_pkg::FRAC_BITS-2:0], 1'b0};
            end
         end
         evr_pkg::OP_SQUARE: begin
            sq_in = sq_full[2*evr_pkg::FRAC_BITS-1:evr_pkg::FRAC_BITS];
         end
         evr_pkg::OP_CUBE: begin
            cube_in = cube_full[2*evr_pkg::FRAC_BITS-1:evr_pkg::FRAC_BITS];
         end
         evr_pkg::OP_SCALE: begin
            prod_in = diff_ff * curve_s;
         end
         evr_pkg::OP_SUM: begin
            // The result lies between start and goal, so truncation is exact.
            current_value_in = start_value_ff + step_full[evr_pkg::VALUE_W-1:0];
         end
         evr_pkg::OP_GOAL: begin
            current_value_in = goal_value_ff;
         end
         evr_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = current_value_ff;
               rsp_settled_in = settled;
            end
         end
         default: begin
         end
      endcase

      // Configuration writes must arrive only while the sequencer is idle; the block itself does not enforce this.
      if (csr_we) begin
         case (csr_index)
            evr_pkg::CSR_MODE: begin
               mode_in = csr_wdata[evr_pkg::MODE_W-1:0];
            end
            evr_pkg::CSR_LATENCY: begin
               latency_in = csr_wdata[evr_pkg::LAT_W-1:0];
            end
            evr_pkg::CSR_INIT: begin
               start_value_in   = signed'(csr_wdata[evr_pkg::VALUE_W-1:0]);
               goal_value_in    = signed'(csr_wdata[evr_pkg::VALUE_W-1:0]);
               current_value_in = signed'(csr_wdata[evr_pkg::VALUE_W-1:0]);
               elapsed_in       = '1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff            <= evr_pkg::STEP_WAIT;
         mode_ff          <= '0;
         latency_ff       <= '0;
         start_value_ff   <= '0;
         goal_value_ff    <= '0;
         current_value_ff <= '0;
         elapsed_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pc_ff            <= pc_in;
         mode_ff          <= mode_in;
         latency_ff       <= latency_in;
         start_value_ff   <= start_value_in;
         goal_value_ff    <= goal_value_in;
         current_value_ff <= current_value_in;
         elapsed_ff       <= elapsed_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      div_cnt_ff     <= div_cnt_in;
      sq_ff          <= sq_in;
      cube_ff        <= cube_in;
      diff_ff        <= diff_in;
      prod_ff        <= prod_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_settled_ff <= rsp_settled_in;
   end

   assign req.ready   = (ctrl.op == evr_pkg::OP_ACCEPT);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.value   = rsp_value_ff;
   assign rsp.settled = rsp_settled_ff;

   // The program counter never leaves the program.
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= evr_pkg::STEP_EMIT)
      else $error("program counter outside the program");

   // An emit step with a free response register loads the current value.
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == evr_pkg::OP_EMIT && out_free)
      |=> (rsp_valid_ff && rsp_value_ff == $past(current_value_ff)))
      else $error("emitted result does not match current value");

   // A settled result always carries the goal.
   a_settled_goal: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == evr_pkg::OP_EMIT && settled) |-> (current_value_ff == goal_value_ff))
      else $error("settled result differs from goal");

   // After the last divide step the remainder is below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == evr_pkg::OP_SQUARE) |-> (rem_ff < latency_ext))
      else $error("divider remainder not reduced");

endmodule

`default_nettype wire

[sim/tb_eased_value_ramp.sv]
// Self-checking testbench for the eased value ramp: random and directed ticks and set-target
// transactions against a cycle-free predictor of the easing curve.
// Depends on evr_pkg, the evr_req_if and evr_rsp_if channels and the eased_value_ramp RTL.
`default_nettype none

module tb_eased_value_ramp;
   timeunit 1ns;
   timeprecision 1ps;

   import evr_pkg::*;

   // The mode field is two bits wide, so the fourth code exists even though
   // no curve is defined for it; likewise the fourth register index.
   localparam logic [MODE_W-1:0]    MODE_NO_CURVE  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED     = 2'd3;
   localparam logic [TIME_BITS-1:0] TICKS_MAX      = '1;
   localparam int                   SETTLE_CYCLES  = 30;
   localparam int                   LONG_HOLD      = 400;
   localparam int                   TIMEOUT_CYCLES = 300000;
   localparam int                   MAX_ERRORS_SHOWN = 10;

   typedef struct packed {
      logic                      func;
      logic signed [VALUE_W-1:0] target;
   } ramp_request_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      settled;
   } ramp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   evr_req_if req_bus ();
   evr_rsp_if rsp_bus ();

   eased_value_ramp dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Transactions waiting to be offered, and the results predicted for
   // transactions that the block has already accepted.
   ramp_request_type queued_requests[$];
   ramp_result_type  expected_outputs[$];

   // Idling controls, changed by the stimulus process between and within phases.
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   bit sender_hold  = 1'b0;
   bit hold_request = 1'b0;
   int hold_left    = 0;

   bit req_taken   = 1'b0;
   int error_count = 0;

   // Predictor state: a private copy of the registers and of the ramp.
   logic [MODE_W-1:0]         ramp_mode    = '0;
   logic [LAT_W-1:0]          ramp_latency = '0;
   logic signed [VALUE_W-1:0] ramp_start   = '0;
   logic signed [VALUE_W-1:0] ramp_goal    = '0;
   logic signed [VALUE_W-1:0] ramp_current = '0;
   logic [TIME_BITS-1:0]      ramp_elapsed = '0;

   // A register write updates the predictor exactly as the block should.
   function automatic void apply_register(input logic [CSR_IDX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_MODE:    ramp_mode = data[MODE_W-1:0];
         CSR_LATENCY: ramp_latency = data[LAT_W-1:0];
         CSR_INIT: begin
            ramp_start   = data;
            ramp_goal    = data;
            ramp_current = data;
            // Pinning the tick count at its maximum reads as settled for any
            // latency the register can hold.
            ramp_elapsed = TICKS_MAX;
         end
         default: ;
      endcase
   endfunction

   // Advances the ramp by one transaction and returns the value it should
   // report. The fraction is elapsed over latency in Q0.16, raised to the
   // power the mode selects, and the step towards the goal is floored.
   function automatic ramp_result_type ease_step(input logic func,
                                                 input logic signed [VALUE_W-1:0] target);
      logic [63:0]        frac;
      logic [63:0]        curve;
      logic signed [63:0] span;
      logic signed [63:0] scaled;
      ramp_result_type    res;
      if (func == FUNC_SET) begin
         ramp_start   = ramp_current;
         ramp_goal    = target;
         ramp_elapsed = '0;
      end else if (ramp_elapsed < ramp_latency && ramp_elapsed != TICKS_MAX) begin
         ramp_elapsed = ramp_elapsed + 1'b1;
      end
      if (ramp_elapsed >= ramp_latency) begin
         ramp_current = ramp_goal;
      end else begin
         frac = ({32'b0, ramp_elapsed} << FRAC_BITS) / {32'b0, ramp_latency};
         case (ramp_mode)
            MODE_LINEAR:  curve = frac;
            MODE_SQUARED: curve = (frac * frac) >> FRAC_BITS;
            MODE_CUBED:   curve = (((frac * frac) >> FRAC_BITS) * frac) >> FRAC_BITS;
            default:      curve = '0;
         endcase
         span = {{32{ramp_goal[VALUE_W-1]}}, ramp_goal}
              - {{32{ramp_start[VALUE_W-1]}}, ramp_start};
         scaled = span * $signed(curve);
         // An arithmetic shift of a signed product rounds towards minus infinity.
         ramp_current = ramp_start + VALUE_W'(scaled >>> FRAC_BITS);
      end
      res.value   = ramp_current;
      res.settled = (ramp_elapsed >= ramp_latency);
      return res;
   endfunction

   // Observation at the rising edge: register writes and accepted requests
   // feed the predictor, and every accepted response is checked against the
   // oldest prediction still waiting.
   always @(posedge clock) begin : observe
      ramp_result_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_bus.valid && req_bus.ready;
         if (csr_we) begin
            apply_register(csr_index, csr_wdata);
         end
         if (req_taken) begin
            expected_outputs.push_back(ease_step(req_bus.func, req_bus.target));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_outputs.size() == 0) begin
               if (error_count < MAX_ERRORS_SHOWN) begin
                  $display("ERROR: unexpected response value=%h settled=%b",
                           rsp_bus.value, rsp_bus.settled);
               end
               error_count++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_bus.value !== want.value || rsp_bus.settled !== want.settled) begin
                  if (error_count < MAX_ERRORS_SHOWN) begin
                     $display("ERROR: value expected %h got %h, settled expected %b got %b",
                              want.value, rsp_bus.value, want.settled, rsp_bus.settled);
                  end
                  error_count++;
               end
            end
         end
      end
   end

   // Request driver. A new transaction is offered on the falling edge only
   // once the previous one has been taken, so valid never drops early.
   always @(negedge clock) begin : drive_requests
      ramp_request_type item;
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.func   <= FUNC_TICK;
         req_bus.target <= '0;
      end else if (!req_bus.valid || req_taken) begin
         if (queued_requests.size() != 0 && !sender_hold &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            item = queued_requests.pop_front();
            req_bus.valid  <= 1'b1;
            req_bus.func   <= item.func;
            req_bus.target <= item.target;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response receiver. A long hold-off, when requested, is counted down here
   // so that the block fills up and has to refuse further requests.
   always @(negedge clock) begin : drive_ready
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic queue_item(input logic func, input logic signed [VALUE_W-1:0] target);
      ramp_request_type item;
      item.func   = func;
      item.target = target;
      queued_requests.push_back(item);
   endtask

   // Registers may only change while nothing is in flight.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Waits until every queued transaction has been taken and answered, then
   // lets the sequencer run out its longest pass.
   task automatic wait_idle();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_bus.valid || expected_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Targets lean on the extremes or on small values now and then, otherwise they are uniform.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return $signed(32'($urandom_range(0, 255)) - 32'd128);
         default: return $signed(32'($urandom));
      endcase
   endfunction

   // Mostly short ramps so that many of them run to completion; now and then
   // zero, and rarely a latency so long that the ramp never finishes.
   function automatic logic [LAT_W-1:0] pick_latency();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r <= 6) return LAT_W'($urandom_range(1, 12));
      if (r <= 8) return LAT_W'($urandom_range(13, 60));
      return LAT_W'($urandom);
   endfunction

   // Most of the random traffic is a set-target followed by a run of ticks
   // that may stop short of the goal, reach it or just pass it; the rest is loose noise.
   task automatic queue_random_items(input int count, input logic [LAT_W-1:0] lat);
      int n;
      int ticks;
      int cap;
      n   = 0;
      cap = (lat > 60) ? 60 : int'(lat);
      while (n < count) begin
         if ($urandom_range(0, 99) < 85) begin
            queue_item(FUNC_SET, pick_value());
            ticks = $urandom_range(0, cap + 2);
            repeat (ticks) queue_item(FUNC_TICK, $signed(32'($urandom)));
            n += 1 + ticks;
         end else begin
            queue_item(1'($urandom), pick_value());
            n++;
         end
      end
   endtask

   // Watchdog: a correct run finishes well inside this many cycles.
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      logic [LAT_W-1:0] lat;
      logic [MODE_W-1:0] m;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Straight out of reset the latency is zero, so the block is settled
      // and a set-target jumps to its goal at once.
      queue_item(FUNC_TICK, 32'sh5555_5555);
      queue_item(FUNC_SET, 32'sh7FFF_FFFF);
      wait_idle();

      // Linear ramp across the whole signed range, starting from a loaded
      // initial value; the first tick shows the load reads as settled, and
      // the extra ticks show the count saturating at the latency.
      write_reg(CSR_MODE, {30'($urandom), MODE_LINEAR});
      write_reg(CSR_LATENCY, 32'd4);
      write_reg(CSR_INIT, 32'h8000_0000);
      queue_item(FUNC_TICK, 32'sh0000_0000);
      queue_item(FUNC_SET, 32'sh7FFF_FFFF);
      repeat (5) queue_item(FUNC_TICK, $signed(32'($urandom)));
      wait_idle();

      // Squared curve heading back down towards the minimum.
      write_reg(CSR_MODE, {30'($urandom), MODE_SQUARED});
      queue_item(FUNC_SET, 32'sh8000_0000);
      repeat (2) queue_item(FUNC_TICK, $signed(32'($urandom)));
      wait_idle();

      // Cubed curve with the largest latency: the fraction stays tiny.
      write_reg(CSR_MODE, {30'($urandom), MODE_CUBED});
      write_reg(CSR_LATENCY, 32'hFFFF_FFFF);
      queue_item(FUNC_SET, 32'sh1234_5678);
      repeat (2) queue_item(FUNC_TICK, $signed(32'($urandom)));
      wait_idle();

      // Without a defined curve the value holds at the start and then jumps
      // to the goal when the latency is reached. The spare register index
      // should have no effect at all.
      write_reg(CSR_MODE, {30'($urandom), MODE_NO_CURVE});
      write_reg(CSR_LATENCY, 32'd3);
      write_reg(CSR_INIT, 32'h0000_0000);
      write_reg(CSR_UNUSED, $urandom);
      queue_item(FUNC_SET, -32'sd1);
      repeat (3) queue_item(FUNC_TICK, $signed(32'($urandom)));
      wait_idle();

      // Lowering the latency below the ticks already counted settles the
      // ramp at the goal on the next tick.
      write_reg(CSR_MODE, {30'($urandom), MODE_LINEAR});
      write_reg(CSR_LATENCY, 32'd10);
      queue_item(FUNC_SET, 32'sh03E8_0000);
      repeat (5) queue_item(FUNC_TICK, $signed(32'($urandom)));
      wait_idle();
      write_reg(CSR_LATENCY, 32'd3);
      queue_item(FUNC_TICK, $signed(32'($urandom)));
      wait_idle();

      // Random phases, one per idling pattern, each under a few settings.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
            default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
         endcase
         for (int s = 0; s < 3; s++) begin
            wait_idle();
            m   = MODE_W'($urandom_range(0, 3));
            lat = pick_latency();
            write_reg(CSR_MODE, {30'($urandom), m});
            write_reg(CSR_LATENCY, lat);
            if ($urandom_range(0, 1) == 1) begin
               write_reg(CSR_INIT, pick_value());
            end
            // With no idling, the receiver first holds off for a long
            // stretch while the sender keeps offering transactions.
            if (phase == 0 && s == 0) begin
               hold_request = 1'b1;
            end
            queue_random_items(35, lat);
            // Under heavy receiver stalls, the sender pauses midway until
            // every outstanding result has come back.
            if (phase == 2 && s == 1) begin
               while (queued_requests.size() > 20) @(negedge clock);
               sender_hold = 1'b1;
               do @(negedge clock);
               while (req_bus.valid || expected_outputs.size() != 0);
               sender_hold = 1'b0;
            end
         end
      end

      wait_idle();
      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
